// ===== design/abrf_pkg.sv =====
// ----------------------------------------------------------------------------
// abrf_pkg
// Shared types, codes and helpers for the banked register file.
// ----------------------------------------------------------------------------
package abrf_pkg;

  // Command codes carried in the slave-side tuser; codes above NOP act as NOP.
  typedef enum logic [2:0] {
    CMD_READ  = 3'd0,
    CMD_WRITE = 3'd1,
    CMD_SWI   = 3'd2,
    CMD_IRQ   = 3'd3,
    CMD_NOP   = 3'd4
  } cmd_e;

  // Register bank groups. User and system modes share the user group.
  typedef enum logic [2:0] {
    GRP_USER = 3'd0,
    GRP_FIQ  = 3'd1,
    GRP_IRQ  = 3'd2,
    GRP_SVC  = 3'd3,
    GRP_ABT  = 3'd4,
    GRP_UND  = 3'd5
  } grp_e;

  // Mode field encodings of the status word.
  localparam logic [4:0] MODE_USR = 5'h10;
  localparam logic [4:0] MODE_FIQ = 5'h11;
  localparam logic [4:0] MODE_IRQ = 5'h12;
  localparam logic [4:0] MODE_SVC = 5'h13;
  localparam logic [4:0] MODE_ABT = 5'h17;
  localparam logic [4:0] MODE_UND = 5'h1B;

  // Special register indexes.
  localparam logic [4:0] IDX_CPSR = 5'd16;
  localparam logic [4:0] IDX_SPSR = 5'd17;

  // Status word after reset: supervisor, IRQ and FIQ masked.
  localparam logic [31:0] CPSR_RESET = 32'h0000_00D3;

  // Exception vectors.
  localparam logic [31:0] VEC_SWI = 32'h0000_0008;
  localparam logic [31:0] VEC_IRQ = 32'h0000_0018;

  // Packed beat widths.
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 40;

  // One command as held in the input register.
  typedef struct packed {
    logic [2:0]  cmd;
    logic [4:0]  reg_index;
    logic [31:0] write_data;
    logic        irq_line;
  } step_req_t;

  // One result as held in the output register.
  typedef struct packed {
    logic [31:0] read_data;
    logic [4:0]  mode_bits;
    logic        thumb_state;
    logic        exception_taken;
  } step_rsp_t;

  // Bank group selected by the mode field; undefined modes use the user bank.
  function automatic grp_e group_of(logic [4:0] mode);
    grp_e g;
    case (mode)
      MODE_FIQ: g = GRP_FIQ;
      MODE_IRQ: g = GRP_IRQ;
      MODE_SVC: g = GRP_SVC;
      MODE_ABT: g = GRP_ABT;
      MODE_UND: g = GRP_UND;
      default:  g = GRP_USER;
    endcase
    return g;
  endfunction

  // Slot of a privileged group in the r13/r14 banks (IRQ first).
  function automatic logic [1:0] splr_slot(grp_e g);
    logic [2:0] s;
    s = 3'(g) - 3'(GRP_IRQ);
    return s[1:0];
  endfunction

  // Slot of a privileged group in the saved status banks (FIQ first).
  function automatic logic [2:0] spsr_slot(grp_e g);
    return 3'(g) - 3'(GRP_FIQ);
  endfunction

endpackage

// ===== design/abrf_core.sv =====
// ----------------------------------------------------------------------------
// abrf_core
// Register state, bank swapping and exception entry for one command a cycle while step_en_i is high.
// ----------------------------------------------------------------------------
module abrf_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_en_i,
  input  abrf_pkg::step_req_t req_i,
  output abrf_pkg::step_rsp_t rsp_o
);
  import abrf_pkg::*;

  // Architectural state, mirroring the visible view plus the stored banks.
  logic [31:0] vis_q       [16];
  logic [31:0] usr_q       [7];
  logic [31:0] fiq_q       [7];
  logic [31:0] splr_q      [4][2];
  logic [31:0] spsr_bank_q [5];
  logic [31:0] cpsr_q;
  logic [31:0] spsr_q;
  grp_e        act_q;

  logic [31:0] vis_d       [16];
  logic [31:0] usr_d       [7];
  logic [31:0] fiq_d       [7];
  logic [31:0] splr_d      [4][2];
  logic [31:0] spsr_bank_d [5];
  logic [31:0] cpsr_d;
  logic [31:0] spsr_d;
  grp_e        act_d;

  logic [31:0] rd;
  logic        exc;
  logic        upd;
  grp_e        grp_new;
  grp_e        exc_grp;
  logic [31:0] ret_addr;
  logic [31:0] vec_addr;

  // Next state: apply the command, then swap banks if the mode group moved,
  // then finish exception entry on the new bank.
  always_comb begin
    vis_d       = vis_q;
    usr_d       = usr_q;
    fiq_d       = fiq_q;
    splr_d      = splr_q;
    spsr_bank_d = spsr_bank_q;
    cpsr_d      = cpsr_q;
    spsr_d      = spsr_q;
    act_d       = act_q;
    rd          = '0;
    exc         = 1'b0;
    upd         = 1'b0;
    exc_grp     = GRP_SVC;
    ret_addr    = vis_q[15] - (cpsr_q[5] ? 32'd2 : 32'd4);
    vec_addr    = VEC_SWI;

    case (req_i.cmd)
      CMD_READ: begin
        if (!req_i.reg_index[4]) begin
          rd = vis_q[req_i.reg_index[3:0]];
        end else if (req_i.reg_index == IDX_CPSR) begin
          rd = cpsr_q;
        end else if (req_i.reg_index == IDX_SPSR) begin
          rd = spsr_q;
        end
      end
      CMD_WRITE: begin
        if (!req_i.reg_index[4]) begin
          vis_d[req_i.reg_index[3:0]] = req_i.write_data;
        end else if (req_i.reg_index == IDX_CPSR) begin
          cpsr_d = req_i.write_data;
          upd    = 1'b1;
        end else if (req_i.reg_index == IDX_SPSR) begin
          spsr_d = req_i.write_data;
        end
      end
      CMD_SWI: begin
        cpsr_d = {cpsr_q[31:8], 1'b1, cpsr_q[6], 1'b0, MODE_SVC};
        upd    = 1'b1;
        exc    = 1'b1;
      end
      CMD_IRQ: begin
        if (req_i.irq_line && !cpsr_q[7]) begin
          cpsr_d   = {cpsr_q[31:8], 1'b1, cpsr_q[6], 1'b0, MODE_IRQ};
          upd      = 1'b1;
          exc      = 1'b1;
          exc_grp  = GRP_IRQ;
          ret_addr = vis_q[15] + (cpsr_q[5] ? 32'd2 : 32'd0);
          vec_addr = VEC_IRQ;
        end
      end
      default: begin
      end
    endcase

    grp_new = group_of(cpsr_d[4:0]);

    if (upd && (grp_new != act_q)) begin
      // Leave the old group.
      if (act_q == GRP_FIQ) begin
        for (int i = 0; i < 7; i++) begin
          fiq_d[i] = vis_d[8 + i];
        end
        for (int i = 0; i < 5; i++) begin
          vis_d[8 + i] = usr_d[i];
        end
        spsr_bank_d[0] = spsr_d;
      end else if (act_q != GRP_USER) begin
        splr_d[splr_slot(act_q)][0]    = vis_d[13];
        splr_d[splr_slot(act_q)][1]    = vis_d[14];
        spsr_bank_d[spsr_slot(act_q)] = spsr_d;
      end else begin
        usr_d[5] = vis_d[13];
        usr_d[6] = vis_d[14];
      end

      // Enter the new group.
      if (grp_new == GRP_FIQ) begin
        for (int i = 0; i < 5; i++) begin
          usr_d[i] = vis_d[8 + i];
        end
        for (int i = 0; i < 7; i++) begin
          vis_d[8 + i] = fiq_d[i];
        end
        spsr_d = spsr_bank_d[0];
      end else if (grp_new != GRP_USER) begin
        vis_d[13] = splr_d[splr_slot(grp_new)][0];
        vis_d[14] = splr_d[splr_slot(grp_new)][1];
        spsr_d    = spsr_bank_d[spsr_slot(grp_new)];
      end else begin
        vis_d[13] = usr_d[5];
        vis_d[14] = usr_d[6];
      end
      act_d = grp_new;
    end

    // Exception entry saves the old status even from the same mode.
    if (exc) begin
      spsr_d                          = cpsr_q;
      spsr_bank_d[spsr_slot(exc_grp)] = cpsr_q;
      vis_d[14]                       = ret_addr;
      vis_d[15]                       = vec_addr;
    end
  end

  // Result of the command, as seen after it.
  always_comb begin
    rsp_o.read_data       = rd;
    rsp_o.mode_bits       = cpsr_d[4:0];
    rsp_o.thumb_state     = cpsr_d[5];
    rsp_o.exception_taken = exc;
  end

  // State registers, loaded when a command leaves the input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 16; i++) begin
        vis_q[i] <= '0;
      end
      for (int i = 0; i < 7; i++) begin
        usr_q[i] <= '0;
        fiq_q[i] <= '0;
      end
      for (int i = 0; i < 4; i++) begin
        splr_q[i][0] <= '0;
        splr_q[i][1] <= '0;
      end
      for (int i = 0; i < 5; i++) begin
        spsr_bank_q[i] <= '0;
      end
      cpsr_q <= CPSR_RESET;
      spsr_q <= '0;
      act_q  <= GRP_SVC;
    end else if (step_en_i) begin
      vis_q       <= vis_d;
      usr_q       <= usr_d;
      fiq_q       <= fiq_d;
      splr_q      <= splr_d;
      spsr_bank_q <= spsr_bank_d;
      cpsr_q      <= cpsr_d;
      spsr_q      <= spsr_d;
      act_q       <= act_d;
    end
  end

endmodule

// ===== design/arm_banked_register_file_top.sv =====
// ----------------------------------------------------------------------------
// arm_banked_register_file_top
// Banked ARM register file with mode switching and exception entry.
// ----------------------------------------------------------------------------
//  Channel  Direction  Beat contents
//  s_axis   in         tuser: cmd; tdata: reg_index, write_data, irq_line
//  m_axis   out        tdata: read_data, mode_bits, thumb_state,
//                      exception_taken
//
//  Each beat is held in the input register and is executed as it moves
//  into the output register, from which its result is offered on m_axis;
//  one beat a cycle is sustained while m_axis_tready stays high.
//  All architectural state sits in flip-flops and is cleared by reset,
//  status word to supervisor with IRQ and FIQ masked; the beat data
//  registers themselves are not reset.
//  A stalled result holds the output register; the input register still
//  takes one more beat before s_axis_tready drops.
// ----------------------------------------------------------------------------
module arm_banked_register_file_top (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // tdata: reg_index[4:0], write_data[36:5], irq_line[37], zero pad [39:38]
  input  logic [abrf_pkg::IN_DATA_W-1:0]       s_axis_tdata,
  // tuser: cmd[2:0]
  input  logic [2:0]                           s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // tdata: read_data[31:0], mode_bits[36:32], thumb_state[37],
  //        exception_taken[38], zero pad [39]
  output logic [abrf_pkg::OUT_DATA_W-1:0]      m_axis_tdata
);
  import abrf_pkg::*;

  logic      in_vld_q;
  step_req_t in_q;
  logic      out_vld_q;
  step_rsp_t out_q;
  step_rsp_t rsp;
  logic      s_beat;
  logic      advance;

  // Handshake: a command advances when the output register is free.
  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;
  assign s_beat        = s_axis_tvalid && s_axis_tready;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_beat) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_beat) begin
      in_q.cmd        <= s_axis_tuser;
      in_q.reg_index  <= s_axis_tdata[4:0];
      in_q.write_data <= s_axis_tdata[36:5];
      in_q.irq_line   <= s_axis_tdata[37];
    end
  end

  // Register state and command execution.
  abrf_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_en_i (advance),
    .req_i     (in_q),
    .rsp_o     (rsp)
  );

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= rsp;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {1'b0, out_q.exception_taken, out_q.thumb_state,
                          out_q.mode_bits, out_q.read_data};

endmodule

// ===== design/abrf_checker.sv =====
// ----------------------------------------------------------------------------
// abrf_checker
// Port-level checks for the banked register file, bound to the top level.
// ----------------------------------------------------------------------------
module abrf_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [abrf_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
  import abrf_pkg::*;

  // A stalled result beat holds its contents.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  // With the output side empty the block always takes a command.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with an empty output");

  // An exception lands in supervisor or IRQ mode in ARM state.
  a_exc_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[38] |->
      !m_axis_tdata[37] &&
      (m_axis_tdata[36:32] == MODE_SVC || m_axis_tdata[36:32] == MODE_IRQ))
    else $error("exception beat with wrong mode or thumb set");

  // The pad bit of a result beat stays zero.
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !m_axis_tdata[39])
    else $error("result pad bit set");

endmodule

bind arm_banked_register_file_top abrf_checker u_abrf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
